// ----- rtl/rfl_pkg.sv -----
// Shared types and constants for the register free list allocator.
// No dependencies; every other file in rtl/ uses this package.
package rfl_pkg;

	localparam int CMD_W  = 2;
	localparam int VREG_W = 6;
	localparam int PREG_W = 4;

	localparam int PHYS_REGS_DEF = 6;
	localparam int VIRT_REGS_DEF = 64;

	// Register code meaning spilled or no register
	localparam logic [PREG_W-1:0] NONE_CODE = 4'hF;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef logic [PREG_W-1:0] preg_t;

endpackage

// ----- rtl/rfl_if.sv -----
// Valid/ready channel interfaces for the allocator request and response items.
// Depends on rfl_pkg for field widths.
interface rfl_req_if;
	logic                      valid;
	logic                      ready;
	logic [rfl_pkg::CMD_W-1:0]  command;
	logic [rfl_pkg::VREG_W-1:0] vreg;

	modport source (output valid, output command, output vreg, input ready);
	modport sink   (input valid, input command, input vreg, output ready);
endinterface

interface rfl_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [rfl_pkg::PREG_W-1:0] phys_reg;

	modport source (output valid, output phys_reg, input ready);
	modport sink   (input valid, input phys_reg, output ready);
endinterface

// ----- rtl/register_free_list_allocator_unit.sv -----
// Register free list allocator: maps virtual register numbers onto a small
// physical register pool. Depends on rfl_pkg and the channel interfaces in rfl_if.sv.
//
// Usage:
//   req carries one item per handshake: command (allocate, free, clear) and
//   vreg. rsp returns exactly one item per request, phys_reg: the register now
//   mapped (allocate), the register released (free), or -1 for spilled/none.
//   An accepted item is registered together with the map memory read in the
//   request stage, then resolved against the slot list and map valid bits and
//   placed in the response register, which drives rsp.valid.
//   Throughput is one item per cycle while rsp is not stalled; the map memory
//   read port and the read-modify-write of the valid bits and slots set that
//   figure, with a write bypass covering back-to-back items to the same vreg.
//   When rsp is stalled the response register holds, the request stage holds
//   behind it and req.ready falls once both are full; nothing is dropped.
//   After arst_n all map entries are invalid and slot i holds register
//   PHYS_REGS-1-i; clear restores the same state directly, since only the
//   per-entry valid bits and the slot flops are reset. No clearing pass.
//   Unknown commands, and allocate or free with vreg values beyond VIRT_REGS,
//   change nothing and answer -1.
module register_free_list_allocator_unit #(
	parameter int PHYS_REGS = rfl_pkg::PHYS_REGS_DEF,
	parameter int VIRT_REGS = rfl_pkg::VIRT_REGS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rfl_req_if.sink      req,
	rfl_rsp_if.source    rsp
);
	import rfl_pkg::*;

	localparam int DEPTH = (VIRT_REGS < (1 << VREG_W)) ? VIRT_REGS : (1 << VREG_W);
	localparam int AW    = $clog2(DEPTH);

	// request stage
	logic           valid_s1;
	cmd_t           cmd_s1;
	logic [VREG_W-1:0] vreg_s1;
	preg_t          rd_s1;

	// state
	logic [DEPTH-1:0]     mapped_q;
	logic [PHYS_REGS-1:0] slot_full_q;
	preg_t                slot_reg_q [PHYS_REGS];
	preg_t                map_mem [DEPTH];

	// response register
	logic  rsp_valid_q;
	preg_t rsp_q;

	logic advance;
	logic accept;
	logic in_range;
	logic [AW-1:0] idx_s1;
	logic hit;

	logic           alloc_found;
	logic [PHYS_REGS-1:0] slot_full_d;
	preg_t          slot_reg_d [PHYS_REGS];
	preg_t          pick;
	preg_t          result;
	logic           mem_we;
	logic           free_done;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	assign in_range = (32'(vreg_s1) < DEPTH);
	assign idx_s1   = vreg_s1[AW-1:0];
	assign hit      = in_range && mapped_q[idx_s1];

	assign rsp.valid    = rsp_valid_q;
	assign rsp.phys_reg = rsp_q;

	always_comb begin
		slot_full_d = slot_full_q;
		slot_reg_d  = slot_reg_q;
		alloc_found = 1'b0;
		free_done   = 1'b0;
		pick        = NONE_CODE;
		result      = NONE_CODE;
		mem_we      = 1'b0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (in_range) begin
					if (hit) begin
						result = rd_s1;
					end else begin
						// take the lowest full slot
						for (int i = 0; i < PHYS_REGS; i++) begin
							if (slot_full_q[i] && !alloc_found) begin
								alloc_found    = 1'b1;
								pick           = slot_reg_q[i];
								slot_full_d[i] = 1'b0;
							end
						end
						mem_we = 1'b1;
						result = pick;
					end
				end
			end
			CMD_FREE: begin
				if (hit && rd_s1 != NONE_CODE) begin
					result = rd_s1;
					// return to the lowest empty slot
					for (int i = 0; i < PHYS_REGS; i++) begin
						if (!slot_full_q[i] && !free_done) begin
							free_done      = 1'b1;
							slot_full_d[i] = 1'b1;
							slot_reg_d[i]  = rd_s1;
						end
					end
				end
			end
			default: begin
				result = NONE_CODE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			mapped_q    <= '0;
			slot_full_q <= '1;
			for (int i = 0; i < PHYS_REGS; i++) begin
				slot_reg_q[i] <= PREG_W'(PHYS_REGS - 1 - i);
			end
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (advance) begin
				if (cmd_s1 == CMD_CLEAR) begin
					mapped_q    <= '0;
					slot_full_q <= '1;
					for (int i = 0; i < PHYS_REGS; i++) begin
						slot_reg_q[i] <= PREG_W'(PHYS_REGS - 1 - i);
					end
				end else begin
					slot_full_q <= slot_full_d;
					slot_reg_q  <= slot_reg_d;
					if (mem_we) begin
						mapped_q[idx_s1] <= 1'b1;
					end else if (cmd_s1 == CMD_FREE && hit) begin
						mapped_q[idx_s1] <= 1'b0;
					end
				end
			end
		end
	end

	// payload registers and map memory
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(req.command);
			vreg_s1 <= req.vreg;
			// bypass the write of the item ahead when it targets the same entry
			if (advance && mem_we && idx_s1 == req.vreg[AW-1:0]) begin
				rd_s1 <= pick;
			end else begin
				rd_s1 <= map_mem[req.vreg[AW-1:0]];
			end
		end
		if (advance && mem_we) begin
			map_mem[idx_s1] <= pick;
		end
		if (advance) begin
			rsp_q <= result;
		end
	end

	a_clear_empties_map: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == CMD_CLEAR |=> mapped_q == '0 && slot_full_q == '1)
		else $error("clear did not empty the map and refill the slots");

	a_rsp_reg_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q != NONE_CODE |-> 32'(rsp_q) < PHYS_REGS)
		else $error("response register outside the physical pool");

	a_alloc_no_slot_gain: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == CMD_ALLOC
		|=> $countones(slot_full_q) <= $past($countones(slot_full_q)))
		else $error("allocate filled a free slot");

	a_alloc_takes_one: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == CMD_ALLOC && in_range && !hit && slot_full_q != '0
		|=> $countones(slot_full_q) + 1 == $past($countones(slot_full_q)))
		else $error("allocate miss did not take exactly one slot");

endmodule

// ----- tb/tb_register_free_list_allocator_unit.sv -----
// Self-checking testbench for register_free_list_allocator_unit: a directed table, then random
// rename traffic, each response checked against a fixed table value or an in-bench model of the
// free list and map. Depends on rfl_pkg and the channel interfaces in rtl/rfl_if.sv.
module tb_register_free_list_allocator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rfl_pkg::*;

	localparam int NUM_RANDOM  = 1000;
	localparam int IDLE_LIMIT  = 300;
	localparam int REPORT_MAX  = 10;

	typedef struct {
		cmd_t              cmd;
		logic [VREG_W-1:0] vreg;
		bit                fixed;
		preg_t             want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rfl_req_if req_ch ();
	rfl_rsp_if rsp_ch ();

	register_free_list_allocator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Rename state mirrored by the bench
	bit    vr_mapped [VIRT_REGS_DEF];
	preg_t vr_map    [VIRT_REGS_DEF];
	bit    slot_full [PHYS_REGS_DEF];
	preg_t slot_reg  [PHYS_REGS_DEF];

	preg_t pending_phys [$];
	int    fail_cnt;
	int    sent_cnt;
	int    rcvd_cnt;
	int    idle_cycles;

	// Slot 0 carries the highest register; the exhausted pool yields spill codes
	dir_row_t dir_rows [0:21] = '{
		'{CMD_ALLOC, 6'd0,  1'b1, 4'd5},
		'{CMD_ALLOC, 6'd0,  1'b1, 4'd5},      // existing mapping returned
		'{CMD_ALLOC, 6'd63, 1'b1, 4'd4},
		'{CMD_FREE,  6'd63, 1'b1, 4'd4},
		'{CMD_FREE,  6'd63, 1'b1, NONE_CODE}, // unmapped number
		'{CMD_NOP,   6'd42, 1'b1, NONE_CODE}, // unknown command
		'{CMD_ALLOC, 6'd21, 1'b0, NONE_CODE},
		'{CMD_ALLOC, 6'd1,  1'b0, NONE_CODE},
		'{CMD_ALLOC, 6'd2,  1'b0, NONE_CODE},
		'{CMD_ALLOC, 6'd3,  1'b0, NONE_CODE},
		'{CMD_ALLOC, 6'd4,  1'b0, NONE_CODE},
		'{CMD_ALLOC, 6'd5,  1'b1, NONE_CODE}, // pool exhausted: spill
		'{CMD_ALLOC, 6'd5,  1'b0, NONE_CODE},
		'{CMD_FREE,  6'd5,  1'b1, NONE_CODE}, // spilled number dropped
		'{CMD_FREE,  6'd2,  1'b0, NONE_CODE},
		'{CMD_ALLOC, 6'd5,  1'b0, NONE_CODE},
		'{CMD_FREE,  6'd0,  1'b0, NONE_CODE},
		'{CMD_CLEAR, 6'd0,  1'b1, NONE_CODE},
		'{CMD_ALLOC, 6'd62, 1'b1, 4'd5},
		'{CMD_NOP,   6'd63, 1'b1, NONE_CODE},
		'{CMD_CLEAR, 6'd63, 1'b1, NONE_CODE},
		'{CMD_FREE,  6'd42, 1'b1, NONE_CODE}
	};

	function automatic void refill_pool();
		for (int i = 0; i < VIRT_REGS_DEF; i++) begin
			vr_mapped[i] = 1'b0;
			vr_map[i]    = NONE_CODE;
		end
		for (int i = 0; i < PHYS_REGS_DEF; i++) begin
			slot_full[i] = 1'b1;
			slot_reg[i]  = preg_t'(PHYS_REGS_DEF - 1 - i);
		end
	endfunction

	// Advance the mirrored state by one item and return the register it reports
	function automatic preg_t rename_step(cmd_t c, logic [VREG_W-1:0] v);
		preg_t r;
		bit    done;
		r    = NONE_CODE;
		done = 1'b0;
		case (c)
			CMD_CLEAR: begin
				refill_pool();
			end
			CMD_ALLOC: begin
				if (vr_mapped[v]) begin
					r = vr_map[v];
				end else begin
					for (int i = 0; i < PHYS_REGS_DEF; i++) begin
						if (!done && slot_full[i]) begin
							r            = slot_reg[i];
							slot_full[i] = 1'b0;
							done         = 1'b1;
						end
					end
					vr_mapped[v] = 1'b1;
					vr_map[v]    = r;
				end
			end
			CMD_FREE: begin
				if (vr_mapped[v]) begin
					r            = vr_map[v];
					vr_mapped[v] = 1'b0;
					vr_map[v]    = NONE_CODE;
					if (r != NONE_CODE) begin
						for (int i = 0; i < PHYS_REGS_DEF; i++) begin
							if (!done && !slot_full[i]) begin
								slot_full[i] = 1'b1;
								slot_reg[i]  = r;
								done         = 1'b1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_item(input cmd_t c, input logic [VREG_W-1:0] v, input preg_t want);
		int gap;
		gap = ((sent_cnt / 50) % 4 == 3) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid   = 1'b1;
		req_ch.command = c;
		req_ch.vreg    = v;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_phys.push_back(want);
		sent_cnt++;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stimulus
	initial begin
		preg_t             want;
		cmd_t              c;
		logic [VREG_W-1:0] v;
		int                roll;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.command = CMD_ALLOC;
		req_ch.vreg    = '0;
		fail_cnt       = 0;
		sent_cnt       = 0;
		refill_pool();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			want = rename_step(dir_rows[i].cmd, dir_rows[i].vreg);
			send_item(dir_rows[i].cmd, dir_rows[i].vreg,
				dir_rows[i].fixed ? dir_rows[i].want : want);
		end

		for (int i = 0; i < NUM_RANDOM; i++) begin
			// hold until the pipeline has drained
			if (i == NUM_RANDOM / 2) begin
				req_ch.valid = 1'b0;
				wait (pending_phys.size() == 0);
				@(negedge clk);
			end
			roll = $urandom_range(0, 99);
			if (roll < 48)
				c = CMD_ALLOC;
			else if (roll < 88)
				c = CMD_FREE;
			else if (roll < 94)
				c = CMD_CLEAR;
			else
				c = CMD_NOP;
			// keep most traffic on a few numbers so the pool fills and spills
			if ($urandom_range(0, 9) < 7)
				v = VREG_W'($urandom_range(0, 11));
			else
				v = VREG_W'($urandom_range(0, VIRT_REGS_DEF - 1));
			want = rename_step(c, v);
			send_item(c, v, want);
		end
		req_ch.valid = 1'b0;

		wait (pending_phys.size() == 0);
		repeat (8) @(posedge clk);
		if (pending_phys.size() != 0)
			fail_cnt++;
		if (fail_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Response side: random stalls, check against the oldest expectation
	initial begin
		int    stall;
		preg_t want;
		rsp_ch.ready = 1'b0;
		rcvd_cnt     = 0;
		forever begin
			stall = ((rcvd_cnt / 40) % 4 == 2) ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			rcvd_cnt++;
			if (pending_phys.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= REPORT_MAX)
					$display("unexpected item: phys_reg=%h", rsp_ch.phys_reg);
			end else begin
				want = pending_phys.pop_front();
				if (rsp_ch.phys_reg !== want) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX)
						$display("item %0d: phys_reg expected %h, got %h",
							rcvd_cnt, want, rsp_ch.phys_reg);
				end
			end
			@(negedge clk);
		end
	end

	// Watchdog: drop the run once nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial idle_cycles = 0;

endmodule
